>>> hw/rtl/sprt_pkg.sv
// ----------------------------------------------------------------------------
// sprt_pkg
// Shared types and codes of the static route prefix table.
// ----------------------------------------------------------------------------
package sprt_pkg;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_FIND   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic        family;
    logic [63:0] dest_hi;
    logic [63:0] dest_lo;
    logic [7:0]  prefix_len;
    logic        router_family;
    logic [63:0] router_hi;
    logic [63:0] router_lo;
  } route_t;

  localparam int unsigned MaxLenV4 = 32;
  localparam int unsigned MaxLenV6 = 128;

  // Top 'bits' bits set in a 64-bit word, bits clamped to 64.
  function automatic logic [63:0] mask_upper(input logic [7:0] bits);
    logic [63:0] m;
    m = '1;
    if (bits == 8'd0) begin
      m = '0;
    end else if (bits < 8'd64) begin
      m = ~({64{1'b1}} >> bits[5:0]);
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/static_route_prefix_table_unit.sv
// ----------------------------------------------------------------------------
// static_route_prefix_table_unit
// Ordered static route list with append, remove, longest prefix lookup and
// find by id, worked by one slot compare unit under a small sequencer.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake          | Payload
// command  | in        | start_i / busy_o   | func_i .. router_lo_i
// result   | out       | done_o (strobe)    | status_o .. next_hop_lo_o
//
// Append, and any command on an empty table, finish without a scan. Find,
// lookup and remove read the slot memory once per cycle while scanning:
// lookup reads every entry, find stops at the first hit, remove then moves
// each later slot down with a read state and a shift state.
// The table memory has a single read port, so each step reads one slot.
// Reset clears the state, entry count, read valid and done_o only; slot contents are written before use.
// The receiver cannot stall: done_o lasts one cycle.
module static_route_prefix_table_unit #(
  parameter int unsigned ROUTE_SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  logic [1:0]   func_i,
  input  logic [31:0]  route_id_i,
  input  logic         ip_version_i,
  input  logic [63:0]  addr_hi_i,
  input  logic [63:0]  addr_lo_i,
  input  logic [7:0]   prefix_len_i,
  input  logic         router_version_i,
  input  logic [63:0]  router_hi_i,
  input  logic [63:0]  router_lo_i,
  output logic         done_o,
  output logic [1:0]   status_o,
  output logic [3:0]   found_slot_o,
  output logic [31:0]  found_id_o,
  output logic [7:0]   found_prefix_len_o,
  output logic         next_hop_version_o,
  output logic [63:0]  next_hop_hi_o,
  output logic [63:0]  next_hop_lo_o
);
  import sprt_pkg::*;

  localparam int unsigned IdxW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(ROUTE_SLOTS + 2);
  localparam logic [CntW-1:0] Slots = CntW'(ROUTE_SLOTS);

  route_t mem_q [ROUTE_SLOTS];
  route_t rd_q;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;      // slot whose read is in flight
  logic            rd_vld_q, rd_vld_d;
  logic [CntW-1:0] rd_ptr_q;          // slot held in rd_q
  logic            have_q, have_d;
  logic [CntW-1:0] best_q, best_d;
  logic [7:0]      best_len_q, best_len_d;
  route_t          best_q_r, best_r_d;
  func_e           func_q;
  logic [31:0]     id_q;
  logic            fam_q;
  logic [63:0]     ahi_q, alo_q;

  logic            done_d;
  status_e         status_d, status_q;
  logic [3:0]      slot_d, slot_q;
  route_t          res_d, res_q;

  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  route_t          mem_wd;
  logic            mem_re;
  logic [IdxW-1:0] mem_ra;

  route_t          new_r;
  logic            match;
  logic            hit_id;
  logic [63:0]     mh, ml;
  logic            len_bad;

  // Build the route that an append stores.
  always_comb begin
    new_r.id            = route_id_i;
    new_r.family        = ip_version_i;
    new_r.dest_hi       = ip_version_i ? addr_hi_i : 64'd0;
    new_r.dest_lo       = ip_version_i ? addr_lo_i : {32'd0, addr_lo_i[31:0]};
    new_r.prefix_len    = prefix_len_i;
    new_r.router_family = router_version_i;
    new_r.router_hi     = router_version_i ? router_hi_i : 64'd0;
    new_r.router_lo     = router_version_i ? router_lo_i : {32'd0, router_lo_i[31:0]};
    len_bad = ip_version_i ? (prefix_len_i > 8'(MaxLenV6))
                           : (prefix_len_i > 8'(MaxLenV4));
  end

  // Shared slot compare unit.
  always_comb begin
    mh = mask_upper(rd_q.prefix_len);
    ml = mask_upper((rd_q.prefix_len > 8'd64) ? (rd_q.prefix_len - 8'd64) : 8'd0);
    if (!fam_q) begin
      match = (((rd_q.dest_lo ^ alo_q) & (mh >> 32)) & 64'h0000_0000_FFFF_FFFF) == 64'd0;
    end else begin
      match = (((rd_q.dest_hi ^ ahi_q) & mh) == 64'd0) &&
              (((rd_q.dest_lo ^ alo_q) & ml) == 64'd0);
    end
    hit_id = (rd_q.id == id_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_e'(func_i) == FUNC_APPEND) state_d = S_DONE;
          else if (count_q == '0) state_d = S_DONE;
          else state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_vld_q && func_q != FUNC_LOOKUP && hit_id) begin
          if (func_q == FUNC_REMOVE && rd_ptr_q + 1'b1 < count_q) state_d = S_READ;
          else state_d = S_DONE;
        end else if (rd_vld_q && rd_ptr_q + 1'b1 >= count_q) begin
          state_d = S_DONE;
        end
      end
      S_READ:  state_d = S_SHIFT;
      S_SHIFT: state_d = (ptr_q + 1'b1 < count_q) ? S_READ : S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_d    = count_q;
    ptr_d      = ptr_q;
    rd_vld_d   = 1'b0;
    have_d     = have_q;
    best_d     = best_q;
    best_len_d = best_len_q;
    best_r_d   = best_q_r;
    done_d     = 1'b0;
    status_d   = status_q;
    slot_d     = slot_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = rd_q;
    mem_re     = 1'b0;
    mem_ra     = ptr_q[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        have_d = 1'b0;
        ptr_d  = '0;
        if (start_i) begin
          status_d = ST_NOT_FOUND;
          slot_d   = '0;
          res_d    = '0;
          if (func_e'(func_i) == FUNC_APPEND) begin
            if (len_bad) begin
              status_d = ST_BAD_LEN;
            end else if (count_q >= Slots) begin
              status_d = ST_FULL;
            end else begin
              mem_we   = 1'b1;
              mem_wa   = count_q[IdxW-1:0];
              mem_wd   = new_r;
              count_d  = count_q + 1'b1;
              status_d = ST_OK;
              slot_d   = 4'(count_q);
              res_d    = new_r;
            end
          end else if (count_q != '0) begin
            mem_re   = 1'b1;
            mem_ra   = '0;
            rd_vld_d = 1'b1;
            ptr_d    = '0;
          end
        end
      end
      S_SCAN: begin
        // Issue the next read while the compare works on the last one.
        if (ptr_q + 1'b1 < count_q && !(rd_vld_q && func_q != FUNC_LOOKUP && hit_id)) begin
          mem_re   = 1'b1;
          mem_ra   = IdxW'(ptr_q + 1'b1);
          ptr_d    = ptr_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          if (func_q == FUNC_LOOKUP) begin
            if (rd_q.family == fam_q && !(have_q && best_len_q >= rd_q.prefix_len)
                && match) begin
              have_d     = 1'b1;
              best_d     = rd_ptr_q;
              best_len_d = rd_q.prefix_len;
              best_r_d   = rd_q;
            end
          end else if (hit_id) begin
            have_d   = 1'b1;
            best_d   = rd_ptr_q;
            best_r_d = rd_q;
            ptr_d    = rd_ptr_q;   // start of the shift for remove
          end
        end
        if (state_d == S_DONE || state_d == S_READ) begin
          if (have_d) begin
            status_d = ST_OK;
            slot_d   = 4'(best_d);
            res_d    = best_r_d;
          end
          if (func_q == FUNC_REMOVE && have_d) count_d = count_q - 1'b1;
        end
      end
      S_READ: begin
        mem_re = 1'b1;
        mem_ra = IdxW'(ptr_q + 1'b1);
      end
      S_SHIFT: begin
        // count_q already dropped by one: move slot ptr+1 down to ptr.
        mem_we = 1'b1;
        mem_wa = ptr_q[IdxW-1:0];
        mem_wd = rd_q;
        ptr_d  = ptr_q + 1'b1;
      end
      S_DONE: begin
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
      done_o   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    rd_ptr_q   <= mem_re ? ptr_d : ptr_q;
    have_q     <= have_d;
    best_q     <= best_d;
    best_len_q <= best_len_d;
    best_q_r   <= best_r_d;
    status_q   <= status_d;
    slot_q     <= slot_d;
    res_q      <= res_d;
    if (state_q == S_IDLE && start_i) begin
      func_q <= func_e'(func_i);
      id_q   <= route_id_i;
      fam_q  <= ip_version_i;
      ahi_q  <= ip_version_i ? addr_hi_i : 64'd0;
      alo_q  <= addr_lo_i;
    end
  end

  assign busy_o             = (state_q != S_IDLE);
  assign status_o           = status_q;
  assign found_slot_o       = slot_q;
  assign found_id_o         = res_q.id;
  assign found_prefix_len_o = res_q.prefix_len;
  assign next_hop_version_o = res_q.router_family;
  assign next_hop_hi_o      = res_q.router_hi;
  assign next_hop_lo_o      = res_q.router_lo;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Slots) else $error("entry count beyond table size");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe lasted two cycles");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_DONE)) else $error("strobe without done state");
  a_err_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (found_id_o == '0 && found_slot_o == '0))
    else $error("error result carries route data");
`endif

endmodule
